FILE: hw/rtl/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// shared constants and result codes of the length prefixed frame receiver
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // default largest payload size of one frame
    localparam int LPFR_MAX_PAYLOAD = 6;

    // byte width of the stream
    localparam int LPFR_BYTE_W = 8;

    // result kinds
    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_CSUM_ERR = 2'd1;
    localparam logic [1:0] KIND_SKIP     = 2'd2;

    // checksum complements the byte sum against this value
    localparam logic [LPFR_BYTE_W-1:0] CSUM_BASE = 8'hFF;

endpackage

FILE: hw/rtl/lpfr_store.sv
// ----------------------------------------------------------------------------
// lpfr_store
// frame byte memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module lpfr_store #(
    parameter int DEPTH = 8
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [lpfr_pkg::LPFR_BYTE_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [lpfr_pkg::LPFR_BYTE_W-1:0] rd_data
);
    import lpfr_pkg::*;

    logic [LPFR_BYTE_W-1:0] mem [DEPTH];
    logic [LPFR_BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/lpfr_ctrl.sv
// ----------------------------------------------------------------------------
// lpfr_ctrl
// header check, frame gathering with running sum, checksum test, skip and error
// results, and replay of a good frame from the frame memory into the result register
// ----------------------------------------------------------------------------
module lpfr_ctrl #(
    parameter int MAX_PAYLOAD = lpfr_pkg::LPFR_MAX_PAYLOAD
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic [lpfr_pkg::LPFR_BYTE_W-1:0]           s_rx_byte,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [1:0]                                 m_kind,
    output logic [lpfr_pkg::LPFR_BYTE_W-1:0]           m_out_byte,
    output logic                                       m_last,
    output logic                                       mem_wr_en,
    output logic [$clog2(MAX_PAYLOAD+2)-1:0]           mem_wr_addr,
    output logic [lpfr_pkg::LPFR_BYTE_W-1:0]           mem_wr_data,
    output logic                                       mem_rd_en,
    output logic [$clog2(MAX_PAYLOAD+2)-1:0]           mem_rd_addr,
    input  logic [lpfr_pkg::LPFR_BYTE_W-1:0]           mem_rd_data
);
    import lpfr_pkg::*;

    localparam int Depth = MAX_PAYLOAD + 2;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    typedef enum logic [0:0] {
        ST_RUN,
        ST_REPLAY
    } state_t;

    state_t                 state_reg,    state_next;
    logic [CntW-1:0]        cnt_reg,      cnt_next;
    logic [CntW-1:0]        len_reg,      len_next;
    logic [LPFR_BYTE_W-1:0] sum_reg,      sum_next;
    logic                   coll_reg,     coll_next;
    logic [CntW-1:0]        rd_idx_reg,   rd_idx_next;
    logic                   dv_reg,       dv_next;
    logic                   dv_last_reg,  dv_last_next;
    logic                   m_valid_reg,  m_valid_next;
    logic [1:0]             m_kind_reg,   m_kind_next;
    logic [LPFR_BYTE_W-1:0] m_byte_reg,   m_byte_next;
    logic                   m_last_reg,   m_last_next;

    logic out_free;
    logic acc;
    logic hdr_ok;
    logic is_pay;
    logic csum_ok;
    logic move;
    logic issue;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_RUN) && out_free;
    assign acc      = s_valid && s_ready;
    assign hdr_ok   = (s_rx_byte != '0) && (s_rx_byte <= LPFR_BYTE_W'(MAX_PAYLOAD));
    assign is_pay   = coll_reg && ((cnt_reg + CntW'(1)) < len_reg);
    assign csum_ok  = (CSUM_BASE - sum_reg) == s_rx_byte;

    // every stored byte goes to the slot given by the byte count
    assign mem_wr_en   = acc && (coll_reg ? (is_pay || csum_ok) : hdr_ok);
    assign mem_wr_addr = cnt_reg[AddrW-1:0];
    assign mem_wr_data = s_rx_byte;

    // replay: memory data moves to the result register when it is free,
    // a new read is issued when the read data register will be free
    assign move        = (state_reg == ST_REPLAY) && dv_reg && out_free;
    assign issue       = (state_reg == ST_REPLAY) && (rd_idx_reg < len_reg) &&
                         (!dv_reg || move);
    assign mem_rd_en   = issue;
    assign mem_rd_addr = rd_idx_reg[AddrW-1:0];

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        coll_next    = coll_reg;
        rd_idx_next  = rd_idx_reg;
        dv_next      = dv_reg;
        dv_last_next = dv_last_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (acc) begin
            if (!coll_reg) begin
                if (hdr_ok) begin
                    cnt_next  = CntW'(1);
                    len_next  = s_rx_byte[CntW-1:0] + CntW'(2);
                    sum_next  = s_rx_byte;
                    coll_next = 1'b1;
                end else begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_SKIP;
                    m_byte_next  = s_rx_byte;
                    m_last_next  = 1'b1;
                end
            end else if (is_pay) begin
                cnt_next = cnt_reg + CntW'(1);
                sum_next = sum_reg + s_rx_byte;
            end else begin
                coll_next = 1'b0;
                cnt_next  = '0;
                if (csum_ok) begin
                    state_next  = ST_REPLAY;
                    rd_idx_next = '0;
                end else begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_CSUM_ERR;
                    m_byte_next  = s_rx_byte;
                    m_last_next  = 1'b1;
                end
            end
        end

        if (move) begin
            m_valid_next = 1'b1;
            m_kind_next  = KIND_BYTE;
            m_byte_next  = mem_rd_data;
            m_last_next  = dv_last_reg;
            dv_next      = 1'b0;
            if (dv_last_reg) begin
                state_next = ST_RUN;
            end
        end

        if (issue) begin
            dv_next      = 1'b1;
            dv_last_next = (rd_idx_reg + CntW'(1)) == len_reg;
            rd_idx_next  = rd_idx_reg + CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            cnt_reg     <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
            coll_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            dv_reg      <= 1'b0;
            dv_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            sum_reg     <= sum_next;
            coll_reg    <= coll_next;
            rd_idx_reg  <= rd_idx_next;
            dv_reg      <= dv_next;
            dv_last_reg <= dv_last_next;
            m_valid_reg <= m_valid_next;
        end
        m_kind_reg <= m_kind_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;

endmodule

FILE: hw/rtl/length_prefixed_frame_receiver.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// byte stream deframer: size header, payload, checksum; good frames replayed
//
//   channel   direction  ports                              transfer
//   s_        in         s_rx_byte                          s_valid & s_ready
//   m_        out        m_kind, m_out_byte, m_last         m_valid & m_ready
//
// header and payload bytes are written to the frame memory as they are taken;
// a good checksum starts a replay of size+2 bytes through the memory read port
// and read data register, one per cycle unless stalled; no input is taken in replay
// skip and checksum error results leave from the result register directly
// reset is synchronous active low; the frame memory needs no clearing
// a stalled result port holds both the replay and the input side
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver #(
    parameter int MAX_PAYLOAD = lpfr_pkg::LPFR_MAX_PAYLOAD
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lpfr_pkg::LPFR_BYTE_W-1:0] s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_kind,
    output logic [lpfr_pkg::LPFR_BYTE_W-1:0] m_out_byte,
    output logic                             m_last
);
    import lpfr_pkg::*;

    localparam int Depth = MAX_PAYLOAD + 2;
    localparam int AddrW = $clog2(Depth);

    logic                   mem_wr_en;
    logic [AddrW-1:0]       mem_wr_addr;
    logic [LPFR_BYTE_W-1:0] mem_wr_data;
    logic                   mem_rd_en;
    logic [AddrW-1:0]       mem_rd_addr;
    logic [LPFR_BYTE_W-1:0] mem_rd_data;

    lpfr_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_byte  (m_out_byte),
        .m_last      (m_last),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    lpfr_store #(
        .DEPTH (Depth)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

FILE: hw/rtl/lpfr_checker.sv
// ----------------------------------------------------------------------------
// lpfr_checker
// port level checks of the frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module lpfr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [lpfr_pkg::LPFR_BYTE_W-1:0] s_rx_byte,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [1:0]                       m_kind,
    input logic [lpfr_pkg::LPFR_BYTE_W-1:0] m_out_byte,
    input logic                             m_last
);
    import lpfr_pkg::*;

    // error and skip results always close their run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_BYTE) |-> m_last)
        else $error("non byte result without last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_BYTE) || (m_kind == KIND_CSUM_ERR) ||
                    (m_kind == KIND_SKIP))
        else $error("undefined result kind");

    // inside a replay run no input is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_BYTE) && !m_last |-> !s_ready)
        else $error("input taken during frame replay");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) &&
                                $stable(m_out_byte) && $stable(m_last))
        else $error("stalled result changed");

    // a waiting input transfer holds its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_rx_byte))
        else $error("stalled input changed");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_rx_byte  (s_rx_byte),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_kind     (m_kind),
    .m_out_byte (m_out_byte),
    .m_last     (m_last)
);
